// ----- rtl/gdfs_pkg.sv -----
// Shared types, constants and codes for the depth-first path search block.
// No dependencies; gdfs_core and the top level refer to this package by scoped names.
`timescale 1ns / 1ps

package gdfs_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MAX_DEGREE   = 4;
   localparam int STACK_DEPTH  = 256;

   localparam int VTX_W  = 6;
   localparam int CNT_W  = 3;
   localparam int LEN_W  = 7;
   localparam int SA_W   = $clog2(STACK_DEPTH);
   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int VC_RESET = 64;
   localparam int ADDR_W = 3;

   localparam logic [ADDR_W-1:0] REG_VERTEX_COUNT = 3'd0;

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_SEARCH = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_PATH     = 2'd0,
      ST_NOPATH   = 2'd1,
      ST_BAD      = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic             kind;
      logic [VTX_W-1:0] vertex_index;
      logic [CNT_W-1:0] neighbor_count;
      logic [VTX_W-1:0] neighbor_a;
      logic [VTX_W-1:0] neighbor_b;
      logic [VTX_W-1:0] neighbor_c;
      logic [VTX_W-1:0] neighbor_d;
      logic [VTX_W-1:0] start_vertex;
      logic [VTX_W-1:0] goal_vertex;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [VTX_W-1:0] path_vertex;
      logic [VTX_W-1:0] step_index;
      logic [LEN_W-1:0] path_length;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]                 count;
      logic [MAX_DEGREE-1:0][VTX_W-1:0] nb;
   } adj_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP,
      S_POPW,
      S_EXP,
      S_WALK,
      S_WALKW,
      S_OUT,
      S_OUTW
   } state_type;

endpackage

// ----- rtl/gdfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gdfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gdfs_core.sv -----
// Search sequencer and datapath: adjacency, parent, stack and path memories.
// Depends on gdfs_pkg and gdfs_ram.
`timescale 1ns / 1ps

module gdfs_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  gdfs_pkg::req_type         req_data,
   output logic                      req_stall,
   input  logic [gdfs_pkg::LEN_W-1:0] vcount,
   input  logic                      rsp_free,
   output gdfs_pkg::emit_type        emit
);

   localparam int VW = gdfs_pkg::VTX_W;
   localparam int LW = gdfs_pkg::LEN_W;
   localparam int SW = gdfs_pkg::SP_W;
   localparam int AW = gdfs_pkg::SA_W;

   gdfs_pkg::state_type state_ff, state_in;
   logic [SW-1:0]  sp_ff, sp_in;
   logic [VW-1:0]  cur_ff, cur_in;
   logic [VW-1:0]  start_ff, start_in;
   logic [VW-1:0]  goal_ff, goal_in;
   logic [2:0]     k_ff, k_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [LW-1:0]  oi_ff, oi_in;
   logic [LW-1:0]  n_ff, n_in;
   logic [gdfs_pkg::MAX_VERTICES-1:0] visited_ff, visited_in;

   // Memory ports.
   logic              adj_we, adj_re;
   logic [VW-1:0]     adj_wa, adj_ra;
   gdfs_pkg::adj_type adj_wd, adj_rd;
   logic              par_we, par_re;
   logic [VW-1:0]     par_wa, par_ra, par_wd, par_rd;
   logic              stk_we, stk_re;
   logic [AW-1:0]     stk_wa, stk_ra;
   logic [VW-1:0]     stk_wd, stk_rd;
   logic              pb_we, pb_re;
   logic [VW-1:0]     pb_wa, pb_ra, pb_wd, pb_rd;

   logic              accept;
   logic [LW-1:0]     n_now;
   logic [2:0]        cnt_eff;
   logic [VW-1:0]     nb_sel;
   logic              out_last;

   gdfs_ram #(.WIDTH($bits(gdfs_pkg::adj_type)), .DEPTH(gdfs_pkg::MAX_VERTICES)) u_adj (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(adj_wd),
      .rd_en(adj_re), .rd_addr(adj_ra), .rd_data(adj_rd));
   gdfs_ram #(.WIDTH(VW), .DEPTH(gdfs_pkg::MAX_VERTICES)) u_par (
      .clock(clock), .wr_en(par_we), .wr_addr(par_wa), .wr_data(par_wd),
      .rd_en(par_re), .rd_addr(par_ra), .rd_data(par_rd));
   gdfs_ram #(.WIDTH(VW), .DEPTH(gdfs_pkg::STACK_DEPTH)) u_stk (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_en(stk_re), .rd_addr(stk_ra), .rd_data(stk_rd));
   gdfs_ram #(.WIDTH(VW), .DEPTH(gdfs_pkg::MAX_VERTICES)) u_pb (
      .clock(clock), .wr_en(pb_we), .wr_addr(pb_wa), .wr_data(pb_wd),
      .rd_en(pb_re), .rd_addr(pb_ra), .rd_data(pb_rd));

   assign accept    = (state_ff == gdfs_pkg::S_IDLE) && rsp_free && req_valid;
   assign req_stall = !((state_ff == gdfs_pkg::S_IDLE) && rsp_free);
   assign n_now     = (vcount < LW'(gdfs_pkg::MAX_VERTICES)) ? vcount
                                                             : LW'(gdfs_pkg::MAX_VERTICES);
   assign cnt_eff   = (adj_rd.count > 3'(gdfs_pkg::MAX_DEGREE)) ? 3'(gdfs_pkg::MAX_DEGREE)
                                                                 : adj_rd.count;
   assign nb_sel    = adj_rd.nb[k_ff[1:0]];
   assign out_last  = (oi_ff + LW'(1)) == len_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gdfs_pkg::S_IDLE: begin
            if (accept && req_data.kind == gdfs_pkg::KIND_SEARCH) begin
               if (!({1'b0, req_data.start_vertex} >= n_now ||
                     {1'b0, req_data.goal_vertex} >= n_now ||
                     req_data.start_vertex == req_data.goal_vertex)) begin
                  state_in = gdfs_pkg::S_POP;
               end
            end
         end
         gdfs_pkg::S_POP: begin
            state_in = (sp_ff == '0) ? gdfs_pkg::S_IDLE : gdfs_pkg::S_POPW;
         end
         gdfs_pkg::S_POPW: begin
            state_in = (stk_rd == goal_ff) ? gdfs_pkg::S_WALK : gdfs_pkg::S_EXP;
         end
         gdfs_pkg::S_EXP: begin
            if (k_ff >= cnt_eff) begin
               state_in = gdfs_pkg::S_POP;
            end else if ({1'b0, nb_sel} >= n_ff) begin
               state_in = gdfs_pkg::S_IDLE;
            end else if (!visited_ff[nb_sel] && sp_ff >= SW'(gdfs_pkg::STACK_DEPTH)) begin
               state_in = gdfs_pkg::S_IDLE;
            end
         end
         gdfs_pkg::S_WALK: begin
            state_in = (cur_ff == start_ff) ? gdfs_pkg::S_OUT : gdfs_pkg::S_WALKW;
         end
         gdfs_pkg::S_WALKW: state_in = gdfs_pkg::S_WALK;
         gdfs_pkg::S_OUT: begin
            if (rsp_free) begin
               state_in = gdfs_pkg::S_OUTW;
            end
         end
         gdfs_pkg::S_OUTW: begin
            state_in = out_last ? gdfs_pkg::S_IDLE : gdfs_pkg::S_OUT;
         end
         default: state_in = gdfs_pkg::S_IDLE;
      endcase
   end

   // Datapath controls and register updates.
   always_comb begin
      sp_in      = sp_ff;
      cur_in     = cur_ff;
      start_in   = start_ff;
      goal_in    = goal_ff;
      k_in       = k_ff;
      len_in     = len_ff;
      oi_in      = oi_ff;
      n_in       = n_ff;
      visited_in = visited_ff;
      adj_we = 1'b0; adj_wa = req_data.vertex_index; adj_re = 1'b0; adj_ra = stk_rd;
      adj_wd.count = req_data.neighbor_count;
      adj_wd.nb    = {req_data.neighbor_d, req_data.neighbor_c,
                      req_data.neighbor_b, req_data.neighbor_a};
      par_we = 1'b0; par_wa = nb_sel; par_wd = cur_ff; par_re = 1'b0; par_ra = cur_ff;
      stk_we = 1'b0; stk_wa = sp_ff[AW-1:0]; stk_wd = nb_sel;
      stk_re = 1'b0; stk_ra = AW'(sp_ff - SW'(1));
      pb_we = 1'b0; pb_wa = len_ff[VW-1:0]; pb_wd = cur_ff;
      pb_re = 1'b0; pb_ra = VW'(len_ff - LW'(1) - oi_ff);
      emit = '0;
      emit.data.last = 1'b1;

      unique case (state_ff)
         gdfs_pkg::S_IDLE: begin
            if (accept) begin
               if (req_data.kind == gdfs_pkg::KIND_LOAD) begin
                  if (req_data.neighbor_count > 3'(gdfs_pkg::MAX_DEGREE)) begin
                     emit.valid = 1'b1;
                     emit.data.status = gdfs_pkg::ST_BAD;
                  end else begin
                     adj_we = 1'b1;
                  end
               end else if ({1'b0, req_data.start_vertex} >= n_now ||
                            {1'b0, req_data.goal_vertex} >= n_now ||
                            req_data.start_vertex == req_data.goal_vertex) begin
                  emit.valid = 1'b1;
                  emit.data.status = gdfs_pkg::ST_BAD;
               end else begin
                  visited_in = '0;
                  start_in   = req_data.start_vertex;
                  goal_in    = req_data.goal_vertex;
                  n_in       = n_now;
                  stk_we     = 1'b1;
                  stk_wa     = '0;
                  stk_wd     = req_data.start_vertex;
                  sp_in      = SW'(1);
               end
            end
         end
         gdfs_pkg::S_POP: begin
            if (sp_ff == '0) begin
               emit.valid = 1'b1;
               emit.data.status = gdfs_pkg::ST_NOPATH;
            end else begin
               stk_re = 1'b1;
               sp_in  = sp_ff - SW'(1);
            end
         end
         gdfs_pkg::S_POPW: begin
            cur_in = stk_rd;
            k_in   = '0;
            len_in = '0;
            if (stk_rd != goal_ff) begin
               visited_in[stk_rd] = 1'b1;
               adj_re = 1'b1;
            end
         end
         gdfs_pkg::S_EXP: begin
            if (k_ff < cnt_eff) begin
               k_in = k_ff + 3'd1;
               if ({1'b0, nb_sel} >= n_ff) begin
                  emit.valid = 1'b1;
                  emit.data.status = gdfs_pkg::ST_BAD;
               end else if (!visited_ff[nb_sel]) begin
                  if (sp_ff >= SW'(gdfs_pkg::STACK_DEPTH)) begin
                     emit.valid = 1'b1;
                     emit.data.status = gdfs_pkg::ST_OVERFLOW;
                  end else begin
                     par_we = 1'b1;
                     stk_we = 1'b1;
                     sp_in  = sp_ff + SW'(1);
                  end
               end
            end
         end
         gdfs_pkg::S_WALK: begin
            pb_we  = 1'b1;
            len_in = len_ff + LW'(1);
            oi_in  = '0;
            par_re = (cur_ff != start_ff);
         end
         gdfs_pkg::S_WALKW: cur_in = par_rd;
         gdfs_pkg::S_OUT: pb_re = rsp_free;
         gdfs_pkg::S_OUTW: begin
            emit.valid            = 1'b1;
            emit.data.status      = gdfs_pkg::ST_PATH;
            emit.data.path_vertex = pb_rd;
            emit.data.step_index  = oi_ff[VW-1:0];
            emit.data.path_length = len_ff;
            emit.data.last        = out_last;
            oi_in                 = oi_ff + LW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gdfs_pkg::S_IDLE;
         sp_ff      <= '0;
         visited_ff <= '0;
      end else begin
         state_ff   <= state_in;
         sp_ff      <= sp_in;
         visited_ff <= visited_in;
      end
      cur_ff   <= cur_in;
      start_ff <= start_in;
      goal_ff  <= goal_in;
      k_ff     <= k_in;
      len_ff   <= len_in;
      oi_ff    <= oi_in;
      n_ff     <= n_in;
   end

endmodule

// ----- rtl/graph_dfs_path_finder_unit.sv -----
// Top level of the depth-first path search block: register port and result register.
// Depends on gdfs_pkg and gdfs_core (which instantiates gdfs_ram).
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Payload
// req_      | in        | req_valid/req_stall | gdfs_pkg::req_type
// rsp_      | out       | rsp_valid/rsp_stall | gdfs_pkg::rsp_type
// csr_      | in/out    | APB psel/penable    | vertex_count at byte address 0
//
// A load request completes when it is accepted. A search pops vertices from the stack,
// expands each popped vertex other than the goal by examining its listed neighbors
// one at a time, and ends with no path when it finds the stack empty; when the goal
// is popped it walks the parent links from the goal back to the start vertex and
// then emits the path vertices one at a time, start vertex first.
// Reset is synchronous and clears the sequencer, stack pointer, visited marks,
// result valid and sets vertex_count to 64; the memories are not cleared.
// A new request is taken only when the sequencer is idle and the result register
// is empty or being emptied; a stalled result holds the sequencer in place.

module graph_dfs_path_finder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  gdfs_pkg::req_type             req_data,
   output logic                          req_stall,
   output logic                          rsp_valid,
   output gdfs_pkg::rsp_type             rsp_data,
   input  logic                          rsp_stall,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gdfs_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic [gdfs_pkg::LEN_W-1:0] vcount_ff, vcount_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   gdfs_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   gdfs_pkg::emit_type         emit;
   logic                       rsp_free;

   // The result register is free when empty or when its result leaves this cycle.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   gdfs_core u_core (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .vcount(vcount_ff), .rsp_free(rsp_free), .emit(emit));

   // Register write decode; only vertex_count exists.
   always_comb begin
      vcount_in = vcount_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == gdfs_pkg::REG_VERTEX_COUNT) begin
         vcount_in = csr_pwdata[gdfs_pkg::LEN_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == gdfs_pkg::REG_VERTEX_COUNT)
                       ? {{(32 - gdfs_pkg::LEN_W){1'b0}}, vcount_ff} : 32'd0;

   // The core only emits when the register is free, so a load never overwrites.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= gdfs_pkg::LEN_W'(gdfs_pkg::VC_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
